// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DCRS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define DCRS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define DCRS_ASSERT(lbl, clk, rstn, prop)
`define DCRS_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// File: rtl/core/dcrs_pkg.sv
// ----------------------------------------------------------------------------
// dcrs_pkg
// Types, constants and helper functions of the DNA context run score core.
// ----------------------------------------------------------------------------
package dcrs_pkg;

    localparam int DCRS_MAX_LEN = 4096;

    localparam int CHAR_W     = 8;
    localparam int POS_W      = 13;
    localparam int SCORE_W    = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int GRP_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DROP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEEP = 2'd2;

    localparam logic [GRP_W-1:0] GRP_A    = 2'd0;
    localparam logic [GRP_W-1:0] GRP_C    = 2'd1;
    localparam logic [GRP_W-1:0] GRP_G    = 2'd2;
    localparam logic [GRP_W-1:0] GRP_T    = 2'd3;
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_T;

    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;
    localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // input transaction accepted
        logic prime;     // fetch the last stored character (wrap predecessor)
        logic scan;      // issue the next scan read
        logic out_load;  // move the score into the output register
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic len_zero;
        logic scan_last;
        logic out_free;
    } t_ctl_sts;

    // Travels alongside a read so it lines up with the registered RAM data.
    typedef struct packed {
        logic             vld;
        logic             wrap;
        logic             first;
        logic [GRP_W-1:0] grp;
    } t_rd_tag;

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] res;
        res = c;
        if (c >= CHAR_UA && c <= CHAR_UZ) begin
            res = c + CASE_OFFSET;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] group_char(input logic [GRP_W-1:0] g);
        logic [CHAR_W-1:0] res;
        case (g)
            GRP_A:   res = CHAR_LA;
            GRP_C:   res = CHAR_LC;
            GRP_G:   res = CHAR_LG;
            GRP_T:   res = CHAR_LT;
            default: res = CHAR_LA;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/dcrs_in_if.sv
// ----------------------------------------------------------------------------
// dcrs_in_if
// Character stream channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface dcrs_in_if;
    import dcrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] seq_char;
    logic              last;

    modport source (output valid, output seq_char, output last, input ready);
    modport sink   (input valid, input seq_char, input last, output ready);
endinterface

// File: rtl/core/dcrs_out_if.sv
// ----------------------------------------------------------------------------
// dcrs_out_if
// Result channel: valid/ready handshake carrying the score and overflow flag.
// ----------------------------------------------------------------------------
interface dcrs_out_if;
    import dcrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               overflow;

    modport source (output valid, output score, output overflow, input ready);
    modport sink   (input valid, input score, input overflow, output ready);
endinterface

// File: rtl/core/dna_context_run_score_core.sv
// ----------------------------------------------------------------------------
// dna_context_run_score_core
// Loads a DNA sequence and scores runs in its grouped predecessor column.
// ----------------------------------------------------------------------------
// Each accepted character is written, lower-cased, to the character store if
// the window setting keeps it and the store has room. After the transaction
// that carries last, a prime step fetches the last stored character, then
// four passes (groups a, c, g, t) read the store one entry per cycle through
// its single read port, followed by a drain step and the hand-off to the
// result register. With nothing stored, scoring goes straight to the hand-off
// with a score of zero. The hand-off waits as long as an earlier result still
// sits unaccepted in the output register. No character is accepted during
// scoring; the next sequence may load while the result waits in the output
// register. No clearing pass is needed after reset.
module dna_context_run_score_core #(
    parameter int MAX_LEN = dcrs_pkg::DCRS_MAX_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dcrs_in_if.sink                         i_in,
    dcrs_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [dcrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dcrs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    t_ctl_cmd          cmd;
    t_ctl_sts          sts;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    dcrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dcrs_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seq_char  (i_in.seq_char),
        .i_last      (i_in.last),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_score     (o_res.score),
        .o_overflow  (o_res.overflow)
    );

    dcrs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule

// File: rtl/core/dcrs_ram.sv
// ----------------------------------------------------------------------------
// dcrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dcrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/dcrs_ctrl.sv
// ----------------------------------------------------------------------------
// dcrs_ctrl
// Sequencer: load phase, wrap fetch, four group passes, result hand-off.
// ----------------------------------------------------------------------------
module dcrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  dcrs_pkg::t_ctl_sts  i_sts,
    output dcrs_pkg::t_ctl_cmd  o_cmd
);
    import dcrs_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_PRIME  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                // With nothing stored the score is simply zero.
                if (i_sts.len_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.prime = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: rtl/core/dcrs_dpath.sv
// ----------------------------------------------------------------------------
// dcrs_dpath
// Window filter, store addressing, run counter and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcrs_dpath #(
    parameter int MAX_LEN = dcrs_pkg::DCRS_MAX_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dcrs_pkg::t_ctl_cmd                  i_cmd,
    output dcrs_pkg::t_ctl_sts                  o_sts,
    input  logic                                i_cfg_we,
    input  logic [dcrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dcrs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [dcrs_pkg::CHAR_W-1:0]         i_seq_char,
    input  logic                                i_last,
    output logic                                o_ram_we,
    output logic [$clog2(MAX_LEN)-1:0]          o_ram_waddr,
    output logic [dcrs_pkg::CHAR_W-1:0]         o_ram_wdata,
    output logic [$clog2(MAX_LEN)-1:0]          o_ram_raddr,
    input  logic [dcrs_pkg::CHAR_W-1:0]         i_ram_rdata,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [dcrs_pkg::SCORE_W-1:0]        o_score,
    output logic                                o_overflow
);
    import dcrs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [MODE_W-1:0]  r_mode,   n_mode;
    logic [POS_W-1:0]   r_wstart, n_wstart;
    logic [POS_W-1:0]   r_wend,   n_wend;
    logic [CW-1:0]      r_kept,   n_kept;
    logic [POS_W-1:0]   r_raw,    n_raw;
    logic               r_ovf,    n_ovf;
    logic [CW-1:0]      r_tally,  n_tally;
    logic [CHAR_W-1:0]  r_prior,  n_prior;
    logic               r_started, n_started;
    logic [AW-1:0]      r_addr,   n_addr;
    logic [GRP_W-1:0]   r_grp,    n_grp;
    t_rd_tag            r_tag,    n_tag;
    logic               r_out_vld, n_out_vld;
    logic [CHAR_W-1:0]  r_wrap,   n_wrap;
    logic [CHAR_W-1:0]  r_prev,   n_prev;
    logic [SCORE_W-1:0] r_out_score, n_out_score;
    logic               r_out_ovf,   n_out_ovf;

    logic              in_window;
    logic              keep;
    logic              full;
    logic [AW-1:0]     last_addr;
    logic [CHAR_W-1:0] tail;

    assign in_window = (r_raw >= r_wstart) && (r_raw < r_wend);
    assign full      = (r_kept == CW'(MAX_LEN));
    assign last_addr = AW'(r_kept - CW'(1));

    always_comb begin
        case (r_mode)
            MODE_DROP: keep = !in_window;
            MODE_KEEP: keep = in_window;
            default:   keep = 1'b1;
        endcase
    end

    assign o_ram_we    = i_cmd.load && keep && !full;
    assign o_ram_waddr = r_kept[AW-1:0];
    assign o_ram_wdata = to_lower(i_seq_char);
    assign o_ram_raddr = i_cmd.prime ? last_addr : r_addr;

    // Position zero takes the last stored character as its predecessor.
    assign tail = r_tag.first ? r_wrap : r_prev;

    assign o_sts.len_zero  = (r_kept == '0);
    assign o_sts.scan_last = (r_grp == GRP_LAST) && (r_addr == last_addr);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    always_comb begin
        n_mode      = r_mode;
        n_wstart    = r_wstart;
        n_wend      = r_wend;
        n_kept      = r_kept;
        n_raw       = r_raw;
        n_ovf       = r_ovf;
        n_tally     = r_tally;
        n_prior     = r_prior;
        n_started   = r_started;
        n_addr      = r_addr;
        n_grp       = r_grp;
        n_out_vld   = r_out_vld;
        n_wrap      = r_wrap;
        n_prev      = r_prev;
        n_out_score = r_out_score;
        n_out_ovf   = r_out_ovf;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_MODE:  n_mode   = i_cfg_wdata[MODE_W-1:0];
                CFG_WINDOW_START: n_wstart = i_cfg_wdata[POS_W-1:0];
                CFG_WINDOW_END:   n_wend   = i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end

        if (i_cmd.load) begin
            if (keep) begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_kept = r_kept + CW'(1);
                end
            end
            if (r_raw != POS_MAX) begin
                n_raw = r_raw + POS_W'(1);
            end
            if (i_last) begin
                n_tally   = '0;
                n_prior   = '0;
                n_started = 1'b0;
                n_addr    = '0;
                n_grp     = GRP_A;
            end
        end

        if (i_cmd.scan) begin
            if (r_addr == last_addr) begin
                n_addr = '0;
                n_grp  = r_grp + GRP_W'(1);
            end else begin
                n_addr = r_addr + AW'(1);
            end
        end

        n_tag.vld   = i_cmd.prime || i_cmd.scan;
        n_tag.wrap  = i_cmd.prime;
        n_tag.first = (r_addr == '0);
        n_tag.grp   = r_grp;

        if (r_tag.vld) begin
            if (r_tag.wrap) begin
                n_wrap = i_ram_rdata;
            end else begin
                if (i_ram_rdata == group_char(r_tag.grp)) begin
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_tally   = CW'(1);
                    end else if (tail != r_prior) begin
                        n_tally = r_tally + CW'(1);
                    end
                    n_prior = tail;
                end
                n_prev = i_ram_rdata;
            end
        end

        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_vld   = 1'b1;
            n_out_score = SCORE_W'(r_tally);
            n_out_ovf   = r_ovf;
            n_kept      = '0;
            n_raw       = '0;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_wstart  <= '0;
            r_wend    <= '0;
            r_kept    <= '0;
            r_raw     <= '0;
            r_ovf     <= 1'b0;
            r_tally   <= '0;
            r_prior   <= '0;
            r_started <= 1'b0;
            r_addr    <= '0;
            r_grp     <= GRP_A;
            r_tag     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_wstart  <= n_wstart;
            r_wend    <= n_wend;
            r_kept    <= n_kept;
            r_raw     <= n_raw;
            r_ovf     <= n_ovf;
            r_tally   <= n_tally;
            r_prior   <= n_prior;
            r_started <= n_started;
            r_addr    <= n_addr;
            r_grp     <= n_grp;
            r_tag     <= n_tag;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrap      <= n_wrap;
        r_prev      <= n_prev;
        r_out_score <= n_out_score;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid = r_out_vld;
    assign o_score     = r_out_score;
    assign o_overflow  = r_out_ovf;

    `DCRS_NEVER(a_load_during_scan, i_clk, i_rst_n, i_cmd.load && (i_cmd.prime || i_cmd.scan))
    `DCRS_ASSERT(a_kept_in_range, i_clk, i_rst_n, r_kept <= CW'(MAX_LEN))
    `DCRS_ASSERT(a_tally_bounded, i_clk, i_rst_n, i_cmd.out_load |-> (r_tally <= r_kept))
    `DCRS_ASSERT(a_tally_needs_start, i_clk, i_rst_n, !r_started |-> (r_tally == '0))
endmodule

// File: tb/tb_dna_context_run_score_core.sv
// ----------------------------------------------------------------------------
// tb_dna_context_run_score_core
// Self-checking bench for the DNA context run score core. Sequences are fed
// through the character channel under all window modes, each result is
// checked against a software scorer, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_dna_context_run_score_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dcrs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_WHOLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               overflow;
    } run_score_t;

    // Mirrors the loader and the grouped predecessor run count.
    class context_run_predictor;
        logic [CHAR_W-1:0] store [DCRS_MAX_LEN];
        int unsigned       kept;
        int unsigned       raw_pos;
        bit                ovf;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  win_lo;
        logic [POS_W-1:0]  win_hi;
        run_score_t        pending_scores [$];
        int unsigned       mismatches;
        int unsigned       overflow_hits;

        function new();
            kept          = 0;
            raw_pos       = 0;
            ovf           = 1'b0;
            mode          = MODE_WHOLE;
            win_lo        = '0;
            win_hi        = '0;
            mismatches    = 0;
            overflow_hits = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WINDOW_MODE:  mode   = val[MODE_W-1:0];
                CFG_WINDOW_START: win_lo = val[POS_W-1:0];
                CFG_WINDOW_END:   win_hi = val[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_char(logic [CHAR_W-1:0] ch, logic lst);
            logic [CHAR_W-1:0] groups [4];
            logic [CHAR_W-1:0] tail;
            logic [CHAR_W-1:0] prev_tail;
            bit                in_win;
            bit                keep;
            bit                begun;
            int unsigned       runs;
            int unsigned       pj;
            run_score_t        res;

            in_win = (raw_pos >= win_lo) && (raw_pos < win_hi);
            if (mode == MODE_DROP) keep = !in_win;
            else if (mode == MODE_KEEP) keep = in_win;
            else keep = 1'b1;

            if (keep) begin
                if (kept < DCRS_MAX_LEN) begin
                    store[kept] = (ch >= CHAR_UA && ch <= CHAR_UZ) ? ch + CASE_OFFSET : ch;
                    kept++;
                end else begin
                    ovf = 1'b1;
                end
            end
            if (raw_pos < POS_MAX) raw_pos++;
            if (!lst) return;

            // Walk the store once per group; the predecessor of entry 0 wraps
            // around to the last stored entry.
            groups    = '{CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT};
            runs      = 0;
            begun     = 1'b0;
            prev_tail = '0;
            for (int g = 0; g < 4; g++) begin
                for (int unsigned j = 0; j < kept; j++) begin
                    if (store[j] == groups[g]) begin
                        pj   = (j == 0) ? kept - 1 : j - 1;
                        tail = store[pj];
                        if (!begun) runs = 1;
                        else if (tail != prev_tail) runs++;
                        begun     = 1'b1;
                        prev_tail = tail;
                    end
                end
            end
            res.score    = runs[SCORE_W-1:0];
            res.overflow = ovf;
            if (ovf) overflow_hits++;
            pending_scores.push_back(res);
            kept    = 0;
            raw_pos = 0;
            ovf     = 1'b0;
        endfunction

        function void report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0d, actual %0d at %0t",
                         what, want_v, got_v, $time);
        endfunction

        function void check_result(logic [SCORE_W-1:0] score, logic ovf_flag);
            run_score_t want;
            if (pending_scores.size() == 0) begin
                report_mismatch("result with no sequence pending", 0, score);
                return;
            end
            want = pending_scores.pop_front();
            if (score !== want.score) report_mismatch("score", want.score, score);
            if (ovf_flag !== want.overflow)
                report_mismatch("overflow", want.overflow, ovf_flag);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dcrs_in_if  char_if ();
    dcrs_out_if score_if ();

    dna_context_run_score_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (char_if),
        .o_res       (score_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    context_run_predictor scorer = new();

    int unsigned chars_sent  = 0;
    int unsigned seq_count   = 0;
    int unsigned cycle_count = 0;
    bit          hold_pending = 1'b0;
    int          src_left  = 0;
    bit          src_quiet = 1'b0;
    int          snk_left  = 0;
    bit          snk_quiet = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[dna_context_run_score_core] ERROR");
            $finish;
        end
    end

    // Gaps come in bursts, so some stretches run back to back.
    function automatic int draw_gap(inout int left, inout bit quiet);
        if (left == 0) begin
            left  = $urandom_range(1, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        logic [CHAR_W-1:0] bases [4];
        logic [CHAR_W-1:0] ch;
        bases = '{CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT};
        if ($urandom_range(0, 4) == 0) begin
            ch = CHAR_W'($urandom_range(0, 255));
        end else begin
            ch = bases[$urandom_range(0, 3)];
            if ($urandom_range(0, 1) == 1) ch = ch - CASE_OFFSET;
        end
        return ch;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic lst);
        int gap;
        gap = draw_gap(src_left, src_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        char_if.valid    <= 1'b1;
        char_if.seq_char <= ch;
        char_if.last     <= lst;
        do @(posedge i_clk); while (char_if.ready !== 1'b1);
        scorer.note_char(ch, lst);
        chars_sent++;
        if (lst) seq_count++;
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++) send_char(txt[k], k == txt.len() - 1);
    endtask

    task automatic send_random_seq(input int len);
        for (int k = 0; k < len; k++) send_char(rand_char(), k == len - 1);
    endtask

    // Drop valid and wait until every pending score has come back.
    task automatic settle();
        @(negedge i_clk);
        char_if.valid <= 1'b0;
        while (scorer.pending_scores.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        scorer.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_window(input logic [MODE_W-1:0] mode, input int unsigned lo,
                              input int unsigned hi);
        cfg_write(CFG_WINDOW_MODE, 32'(mode));
        cfg_write(CFG_WINDOW_START, lo);
        cfg_write(CFG_WINDOW_END, hi);
    endtask

    initial begin : drain_results
        int gap;
        score_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(snk_left, snk_quiet);
            // A long hold lets the output register and the loader back up.
            if (hold_pending) begin
                hold_pending = 1'b0;
                gap          = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                score_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            score_if.ready <= 1'b1;
            do @(posedge i_clk); while (score_if.valid !== 1'b1);
            scorer.check_result(score_if.score, score_if.overflow);
        end
    end

    initial begin : stimulus
        int          rand_items;
        int          target;
        int          phase;
        int          len;
        int          pick;
        int unsigned lo;
        int unsigned hi;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        char_if.valid    = 1'b0;
        char_if.seq_char = '0;
        char_if.last     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: whole sequence kept.
        send_text("A");
        send_text("aCgT");
        send_text("xyZ@[");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("G", 1'b1);
        settle();

        set_window(MODE_DROP, 1, 3);
        send_text("gattaca");
        settle();
        set_window(MODE_KEEP, 2, 5);
        send_text("ccATGca");
        send_text("a");
        settle();

        // Empty windows: keep mode stores nothing, drop mode stores all.
        set_window(MODE_KEEP, 5, 5);
        send_text("acg");
        settle();
        set_window(MODE_DROP, 7, 3);
        send_text("tgca");
        settle();
        set_window(MODE_SPARE, 1, 3);
        send_text("ttaG");
        settle();

        // Capacity: more kept characters than the store holds.
        set_window(MODE_WHOLE, 0, 4096);
        send_random_seq(4100);
        settle();
        set_window(MODE_KEEP, 4096, 4096);
        send_text("gc");
        settle();
        // Drop the first 4096 positions; the raw position saturates further on.
        set_window(MODE_DROP, 0, 4096);
        send_random_seq(8200);
        settle();

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                lo = $urandom_range(0, 4096);
                hi = $urandom_range(0, 4096);
            end else begin
                lo = $urandom_range(0, 48);
                hi = $urandom_range(0, 48);
            end
            set_window(MODE_W'($urandom_range(0, 3)), lo, hi);
            if (phase == 1) hold_pending = 1'b1;
            target = rand_items + $urandom_range(150, 300);
            while (rand_items < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) len = $urandom_range(1, 24);
                else if (pick < 97) len = $urandom_range(25, 120);
                else len = $urandom_range(121, 400);
                send_random_seq(len);
                rand_items += len;
            end
            settle();
            phase++;
        end

        repeat (64) @(posedge i_clk);
        $display("Scored %0d sequences from %0d characters, %0d of them past capacity.",
                 seq_count, chars_sent, scorer.overflow_hits);
        $display("All window modes, empty and full-range windows and a long output stall ran.");
        if (scorer.mismatches == 0 && scorer.pending_scores.size() == 0) begin
            $display("[dna_context_run_score_core] OK");
        end else begin
            $display("%0d mismatches", scorer.mismatches);
            $display("[dna_context_run_score_core] ERROR");
        end
        $finish;
    end
endmodule
